### sv/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// expr must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### sv/lpdf_pkg.sv
// Shared types and constants of the length-prefixed field deframer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lpdf_pkg;
   localparam int BYTE_W  = 8;
   localparam int FIELD_W = 2;
   localparam int LEN_W   = 31;

   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 31'd1024;

   typedef struct packed {
      logic [BYTE_W-1:0]  payload_byte;
      logic [FIELD_W-1:0] field_index;
      logic               byte_valid;
      logic               last_in_field;
      logic               last_in_message;
      logic               length_error;
   } rsp_type;
endpackage
`default_nettype wire

### sv/three_field_length_prefix_deframer.sv
// Deframer for messages of length-prefixed fields (big-endian length, then payload).
// Depends on lpdf_pkg and assert_macros.svh.
// Bytes go input reg -> result reg; parser state is a few counters updated in one pass.
// Throughput: one byte per cycle unless a result waits on rsp_stall.
// Reset (synchronous, active high) returns to field 0 awaiting length bytes, limit 1024,
// and empties both the input and result registers.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module three_field_length_prefix_deframer #(
   parameter int LENGTH_PREFIX_BYTES = 4,
   parameter int FIELDS_PER_MESSAGE  = 3
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration: field length limit
   input  wire logic                            csr_wr_en,
   input  wire logic [lpdf_pkg::LEN_W-1:0]      csr_wr_data,
   // byte stream in
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [lpdf_pkg::BYTE_W-1:0]     req_data_byte,
   // deframed transactions out
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [lpdf_pkg::BYTE_W-1:0]          rsp_payload_byte,
   output logic [lpdf_pkg::FIELD_W-1:0]         rsp_field_index,
   output logic                                 rsp_byte_valid,
   output logic                                 rsp_last_in_field,
   output logic                                 rsp_last_in_message,
   output logic                                 rsp_length_error
);
   // Length accumulator holds the prefix bytes seen so far.
   localparam int ACC_W = 8 * LENGTH_PREFIX_BYTES;
   localparam logic [1:0] LAST_CNT = 2'(LENGTH_PREFIX_BYTES - 1);
   localparam logic [lpdf_pkg::FIELD_W-1:0] LAST_FIELD =
      lpdf_pkg::FIELD_W'(FIELDS_PER_MESSAGE - 1);

   // config register
   logic [lpdf_pkg::LEN_W-1:0]   max_len_ff;

   // input register (also the skid stage on the request side)
   logic                         s1_valid_ff;
   logic [lpdf_pkg::BYTE_W-1:0]  s1_byte_ff;

   // parser state
   logic                         in_payload_ff, in_payload_in;
   logic [1:0]                   cnt_ff, cnt_in;
   logic [lpdf_pkg::FIELD_W-1:0] field_ff, field_in;
   logic [ACC_W-1:0]             acc_ff, acc_in;
   logic [lpdf_pkg::LEN_W-1:0]   rem_ff, rem_in;

   // result register
   logic                         rsp_valid_ff;
   lpdf_pkg::rsp_type            rsp_ff, rsp_in;

   // decode of the current byte
   logic [ACC_W-1:0]             len_full;
   logic [31:0]                  len32;
   logic                         len_bad;
   logic                         produce;
   logic                         out_free;
   logic                         proc;
   logic                         err_load;

   always_comb begin
      len_full      = ACC_W'({acc_ff, s1_byte_ff});
      len32         = 32'(len_full);
      // bit 31 only reachable with a four-byte prefix (negative length)
      len_bad       = len32[31] || (len32[30:0] > max_len_ff);

      in_payload_in = in_payload_ff;
      cnt_in        = cnt_ff;
      field_in      = field_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      produce       = 1'b0;
      err_load      = 1'b0;
      rsp_in        = '0;
      rsp_in.field_index = field_ff;

      if (in_payload_ff) begin
         // payload byte: count down, close the field on the last one
         produce              = 1'b1;
         rem_in               = rem_ff - 1'b1;
         rsp_in.payload_byte  = s1_byte_ff;
         rsp_in.byte_valid    = 1'b1;
         if (rem_ff == lpdf_pkg::LEN_W'(1)) begin
            rsp_in.last_in_field   = 1'b1;
            rsp_in.last_in_message = (field_ff >= LAST_FIELD);
            in_payload_in          = 1'b0;
            field_in = (field_ff >= LAST_FIELD) ? '0 : field_ff + 1'b1;
         end
      end else if (cnt_ff != LAST_CNT) begin
         // more prefix bytes to come
         cnt_in = cnt_ff + 1'b1;
         acc_in = len_full;
      end else begin
         // prefix complete
         cnt_in = '0;
         acc_in = '0;
         priority if (len_bad) begin
            produce             = 1'b1;
            err_load            = 1'b1;
            rsp_in.length_error = 1'b1;
            field_in            = '0;
         end else if (len32 == 32'd0) begin
            // empty field marker
            produce                = 1'b1;
            rsp_in.last_in_field   = 1'b1;
            rsp_in.last_in_message = (field_ff >= LAST_FIELD);
            field_in = (field_ff >= LAST_FIELD) ? '0 : field_ff + 1'b1;
         end else begin
            rem_in        = len32[30:0];
            in_payload_in = 1'b1;
         end
      end
   end

   // A byte that yields nothing moves on even if the output is full.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign proc      = s1_valid_ff && (!produce || out_free);
   assign req_stall = s1_valid_ff && !proc;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff    <= lpdf_pkg::MAX_LEN_RESET;
         s1_valid_ff   <= 1'b0;
         in_payload_ff <= 1'b0;
         cnt_ff        <= '0;
         field_ff      <= '0;
         acc_ff        <= '0;
         rem_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end

         // input register: refill whenever it empties or moves on
         if (req_valid && !req_stall) begin
            s1_valid_ff <= 1'b1;
            s1_byte_ff  <= req_data_byte;
         end else if (proc) begin
            s1_valid_ff <= 1'b0;
         end

         if (proc) begin
            in_payload_ff <= in_payload_in;
            cnt_ff        <= cnt_in;
            field_ff      <= field_in;
            acc_ff        <= acc_in;
            rem_ff        <= rem_in;
         end

         // result register
         if (proc && produce) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= rsp_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload_byte    = rsp_ff.payload_byte;
   assign rsp_field_index     = rsp_ff.field_index;
   assign rsp_byte_valid      = rsp_ff.byte_valid;
   assign rsp_last_in_field   = rsp_ff.last_in_field;
   assign rsp_last_in_message = rsp_ff.last_in_message;
   assign rsp_length_error    = rsp_ff.length_error;

   `ASSERT_IMPLIES(a_err_no_data, clock, reset, rsp_valid_ff, !(rsp_ff.byte_valid && rsp_ff.length_error), "error transaction carries data")
   `ASSERT_IMPLIES(a_lim_lif, clock, reset, rsp_valid_ff && rsp_ff.last_in_message, rsp_ff.last_in_field, "message end without field end")
   `ASSERT_IMPLIES(a_field_range, clock, reset, rsp_valid_ff, rsp_ff.field_index <= LAST_FIELD, "field index out of range")
   `ASSERT_NEXT(a_err_resync, clock, reset, proc && err_load, field_ff == '0 && !in_payload_ff, "no resync after length error")
   `ASSERT_IMPLIES(a_rem_nonzero, clock, reset, in_payload_ff, rem_ff != '0, "payload state with zero bytes left")
endmodule
`default_nettype wire
